// ===== rtl/core/pjdr_pkg.sv =====
// Shared widths, pipeline depths and pairing codes for the photon-jet delta-R pairing block.
package pjdr_pkg;

    // Field widths of one input item
    localparam int ETA_W  = 12;
    localparam int PHI_W  = 11;

    // Internal and result widths
    localparam int DETA_W   = 12;               // |eta_ph - eta_j| <= 4095
    localparam int DPHI_W   = 11;               // folded |phi_ph - phi_j| <= 2047
    localparam int SUMSQ_W  = 25;               // deta^2 + dphi^2 < 2^25
    localparam int ROOT_W   = 13;               // floor sqrt fits 13 bits
    localparam int RAD_W    = 2 * ROOT_W;       // radicand padded to whole bit pairs
    localparam int REM_W    = ROOT_W + 3;       // partial remainder after the pair shift
    localparam int DR_W     = 13;
    localparam int PAIR_W   = 2;
    localparam int N_PAIRS  = 4;

    // Stream packing
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // Default half turn of phi (pi in phi units)
    localparam int PHI_HALF_TURN_DEF = 804;

    // Pipeline depth: diff, square, sum, one root bit per stage, two merge stages
    localparam int LANE_STAGES  = 3 + ROOT_W;
    localparam int MERGE_STAGES = 2;
    localparam int PIPE_STAGES  = LANE_STAGES + MERGE_STAGES;

    // Pairing codes
    localparam logic [PAIR_W-1:0] PAIR_P1J1 = 2'd0;
    localparam logic [PAIR_W-1:0] PAIR_P1J2 = 2'd1;
    localparam logic [PAIR_W-1:0] PAIR_P2J1 = 2'd2;
    localparam logic [PAIR_W-1:0] PAIR_P2J2 = 2'd3;

    typedef logic [DR_W-1:0] dr_t;
    typedef dr_t [N_PAIRS-1:0] dr_vec_t;

endpackage

// ===== rtl/core/photon_jet_delta_r_pairing.sv =====
// Top level of the photon-jet delta-R pairing block: four lanes, merge and pipeline control.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: eight eta/phi fields, 92 of 96 bits
//  m_      | out | m_tvalid/m_tready  | m_tdata: dr_min, dr_other; m_tuser: best_pairing
//
//  One item per clock sustained while m_tready stays high; a result is offered from the last
//  of 18 register stages: 3 arithmetic, 13 square-root stages of one bit each, 2 merge stages.
//  Each stage advances when it is empty or the stage after it advances, so bubbles
//  collapse and input keeps flowing while a result waits, until every stage holds an item.
//  Synchronous active-low reset clears only the stage valid bits.
//  Distances keep the unit of their inputs; no rescaling by the fraction bits takes place.
module photon_jet_delta_r_pairing #(
    parameter int PHI_HALF_TURN = pjdr_pkg::PHI_HALF_TURN_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [11:0] photon_a_eta, [22:12] photon_a_phi, [34:23] photon_b_eta, [45:35] photon_b_phi,
    // [57:46] jet_a_eta, [68:58] jet_a_phi, [80:69] jet_b_eta, [91:81] jet_b_phi, rest zero
    input  logic [pjdr_pkg::S_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [12:0] dr_min, [25:13] dr_other, [31:26] zero
    output logic [pjdr_pkg::M_TDATA_W-1:0]      m_tdata,
    // [1:0] best_pairing
    output logic [pjdr_pkg::M_TUSER_W-1:0]      m_tuser
);
    import pjdr_pkg::*;

    logic [PIPE_STAGES-1:0]      valid_reg;
    logic [PIPE_STAGES-1:0]      valid_next;
    logic [PIPE_STAGES-1:0]      stage_en;

    logic signed [ETA_W-1:0]     ph_eta [2];
    logic signed [PHI_W-1:0]     ph_phi [2];
    logic signed [ETA_W-1:0]     jt_eta [2];
    logic signed [PHI_W-1:0]     jt_phi [2];

    dr_vec_t                     dr_lane;
    dr_t                         dr_min;
    dr_t                         dr_other;
    logic [PAIR_W-1:0]           best_pairing;

    // Unpack the input fields
    assign ph_eta[0] = s_tdata[11:0];
    assign ph_phi[0] = s_tdata[22:12];
    assign ph_eta[1] = s_tdata[34:23];
    assign ph_phi[1] = s_tdata[45:35];
    assign jt_eta[0] = s_tdata[57:46];
    assign jt_phi[0] = s_tdata[68:58];
    assign jt_eta[1] = s_tdata[80:69];
    assign jt_phi[1] = s_tdata[91:81];

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        stage_en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_tready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PIPE_STAGES; i++) begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // One lane per pairing: lane index bit 1 picks the photon, bit 0 the jet
    for (genvar p = 0; p < N_PAIRS; p++) begin : g_lane
        pjdr_lane #(
            .PHI_HALF_TURN (PHI_HALF_TURN)
        ) u_lane (
            .aclk       (aclk),
            .stage_en   (stage_en[LANE_STAGES-1:0]),
            .photon_eta (ph_eta[p/2]),
            .photon_phi (ph_phi[p/2]),
            .jet_eta    (jt_eta[p%2]),
            .jet_phi    (jt_phi[p%2]),
            .dr         (dr_lane[p])
        );
    end

    pjdr_merge u_merge (
        .aclk         (aclk),
        .stage_en     (stage_en[PIPE_STAGES-1:LANE_STAGES]),
        .dr_lane      (dr_lane),
        .dr_min       (dr_min),
        .dr_other     (dr_other),
        .best_pairing (best_pairing)
    );

    // Drive the result channel
    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[PIPE_STAGES-1];
    assign m_tdata  = {(M_TDATA_W - 2 * DR_W)'(0), dr_other, dr_min};
    assign m_tuser  = best_pairing;

`ifndef SYNTHESIS
    // The reported minimum never exceeds the complementary distance
    a_min_le_other: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:0] <= m_tdata[25:13]))
        else $error("dr_min exceeds dr_other");

    // Input is refused only when every stage holds an item
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // An accepted input always lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> valid_reg[0])
        else $error("accepted input lost at the first stage");

    // A result that is not taken stays valid
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[PIPE_STAGES-1] && !m_tready) |=> valid_reg[PIPE_STAGES-1])
        else $error("pending result dropped");
`endif

endmodule

// ===== rtl/core/pjdr_lane.sv =====
// One pairing lane: eta/phi differences, phi fold, squares and a pipelined floor square root.
module pjdr_lane #(
    parameter int PHI_HALF_TURN = pjdr_pkg::PHI_HALF_TURN_DEF
) (
    input  logic                                  aclk,
    input  logic [pjdr_pkg::LANE_STAGES-1:0]      stage_en,
    input  logic signed [pjdr_pkg::ETA_W-1:0]     photon_eta,
    input  logic signed [pjdr_pkg::PHI_W-1:0]     photon_phi,
    input  logic signed [pjdr_pkg::ETA_W-1:0]     jet_eta,
    input  logic signed [pjdr_pkg::PHI_W-1:0]     jet_phi,
    output pjdr_pkg::dr_t                         dr
);
    import pjdr_pkg::*;

    // Width that holds a full turn and any raw phi difference
    localparam int FULL_W = $clog2(2 * PHI_HALF_TURN + 1);
    localparam int FOLD_W = (FULL_W > DPHI_W) ? FULL_W : DPHI_W;
    localparam logic [FOLD_W-1:0] HALF_TURN = FOLD_W'(PHI_HALF_TURN);
    localparam logic [FOLD_W-1:0] FULL_TURN = FOLD_W'(2 * PHI_HALF_TURN);

    logic signed [ETA_W:0]   eta_diff;
    logic signed [PHI_W:0]   phi_diff;
    logic [ETA_W:0]          eta_mag;
    logic [PHI_W:0]          phi_mag;
    logic [FOLD_W-1:0]       phi_raw;
    logic [FOLD_W-1:0]       phi_fold;

    logic [DETA_W-1:0]       deta_reg;
    logic [DPHI_W-1:0]       dphi_reg;
    logic [2*DETA_W-1:0]     sq_eta_reg;
    logic [2*DPHI_W-1:0]     sq_phi_reg;
    logic [SUMSQ_W-1:0]      sumsq_reg;

    logic [REM_W-1:0]        rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]       root_reg [ROOT_W];
    logic [RAD_W-1:0]        rad_reg  [ROOT_W];

    // Absolute differences
    always_comb begin
        eta_diff = {photon_eta[ETA_W-1], photon_eta} - {jet_eta[ETA_W-1], jet_eta};
        phi_diff = {photon_phi[PHI_W-1], photon_phi} - {jet_phi[PHI_W-1], jet_phi};
        eta_mag  = eta_diff[ETA_W] ? (~eta_diff + 1'b1) : eta_diff;
        phi_mag  = phi_diff[PHI_W] ? (~phi_diff + 1'b1) : phi_diff;
        phi_raw  = FOLD_W'(phi_mag[DPHI_W-1:0]);
    end

    // Fold phi to the short way round the circle
    always_comb begin
        if (phi_raw > HALF_TURN) begin
            if (phi_raw <= FULL_TURN) begin
                phi_fold = FULL_TURN - phi_raw;
            end else begin
                phi_fold = phi_raw - FULL_TURN;
            end
        end else begin
            phi_fold = phi_raw;
        end
    end

    // Register differences, squares and their sum
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            deta_reg <= eta_mag[DETA_W-1:0];
            dphi_reg <= phi_fold[DPHI_W-1:0];
        end
        if (stage_en[1]) begin
            sq_eta_reg <= deta_reg * deta_reg;
            sq_phi_reg <= dphi_reg * dphi_reg;
        end
        if (stage_en[2]) begin
            sumsq_reg <= SUMSQ_W'(sq_eta_reg) + SUMSQ_W'(sq_phi_reg);
        end
    end

    // Floor square root, one result bit per stage
    for (genvar k = 0; k < ROOT_W; k++) begin : g_root
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rad_next;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RAD_W'(sumsq_reg);
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        always_comb begin
            shifted   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial     = REM_W'({root_in, 2'b01});
            take      = (shifted >= trial);
            rem_next  = take ? (shifted - trial) : shifted;
            root_next = {root_in[ROOT_W-2:0], take};
            rad_next  = {rad_in[RAD_W-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (stage_en[3+k]) begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                rad_reg[k]  <= rad_next;
            end
        end
    end

    assign dr = DR_W'(root_reg[ROOT_W-1]);

endmodule

// ===== rtl/core/pjdr_merge.sv =====
// Merge stages: pick the smallest of four lane distances and its complementary distance.
module pjdr_merge (
    input  logic                                   aclk,
    input  logic [pjdr_pkg::MERGE_STAGES-1:0]      stage_en,
    input  pjdr_pkg::dr_vec_t                      dr_lane,
    output pjdr_pkg::dr_t                          dr_min,
    output pjdr_pkg::dr_t                          dr_other,
    output logic [pjdr_pkg::PAIR_W-1:0]            best_pairing
);
    import pjdr_pkg::*;

    dr_vec_t            dr_hold_reg;
    dr_t                min_lo_reg;
    dr_t                min_hi_reg;
    logic [PAIR_W-1:0]  best_lo_reg;
    logic [PAIR_W-1:0]  best_hi_reg;

    dr_t                min_lo_next;
    dr_t                min_hi_next;
    logic [PAIR_W-1:0]  best_lo_next;
    logic [PAIR_W-1:0]  best_hi_next;

    dr_t                dr_min_next;
    dr_t                dr_other_next;
    logic [PAIR_W-1:0]  best_next;

    dr_t                dr_min_reg;
    dr_t                dr_other_reg;
    logic [PAIR_W-1:0]  best_reg;

    // First level: compare within each photon; ties keep the lower pairing
    always_comb begin
        if (dr_lane[1] < dr_lane[0]) begin
            min_lo_next  = dr_lane[1];
            best_lo_next = PAIR_P1J2;
        end else begin
            min_lo_next  = dr_lane[0];
            best_lo_next = PAIR_P1J1;
        end
        if (dr_lane[3] < dr_lane[2]) begin
            min_hi_next  = dr_lane[3];
            best_hi_next = PAIR_P2J2;
        end else begin
            min_hi_next  = dr_lane[2];
            best_hi_next = PAIR_P2J1;
        end
    end

    // Second level: overall minimum and the other photon with the other jet
    always_comb begin
        if (min_hi_reg < min_lo_reg) begin
            dr_min_next = min_hi_reg;
            best_next   = best_hi_reg;
        end else begin
            dr_min_next = min_lo_reg;
            best_next   = best_lo_reg;
        end
        unique case (best_next)
            PAIR_P1J1: dr_other_next = dr_hold_reg[3];
            PAIR_P1J2: dr_other_next = dr_hold_reg[2];
            PAIR_P2J1: dr_other_next = dr_hold_reg[1];
            PAIR_P2J2: dr_other_next = dr_hold_reg[0];
            default:   dr_other_next = dr_hold_reg[0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            dr_hold_reg <= dr_lane;
            min_lo_reg  <= min_lo_next;
            min_hi_reg  <= min_hi_next;
            best_lo_reg <= best_lo_next;
            best_hi_reg <= best_hi_next;
        end
        if (stage_en[1]) begin
            dr_min_reg   <= dr_min_next;
            dr_other_reg <= dr_other_next;
            best_reg     <= best_next;
        end
    end

    assign dr_min       = dr_min_reg;
    assign dr_other     = dr_other_reg;
    assign best_pairing = best_reg;

endmodule
